// ===== rtl/core/tll_pkg.sv =====
// ----------------------------------------------------------------------------
// tll_pkg
// Shared types and constants of the toy language lexer: token kinds,
// character codes, command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tll_pkg;

  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 6;
  localparam int KIND_W  = 4;
  localparam int KW_LEN  = 8;

  // token kinds
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t K_KEYWORD = 4'd0;
  localparam kind_t K_IDENT   = 4'd1;
  localparam kind_t K_NUMBER  = 4'd2;
  localparam kind_t K_ASSIGN  = 4'd3;
  localparam kind_t K_SEMI    = 4'd4;
  localparam kind_t K_LPAREN  = 4'd5;
  localparam kind_t K_RPAREN  = 4'd6;
  localparam kind_t K_STRING  = 4'd7;
  localparam kind_t K_OPER    = 4'd8;
  localparam kind_t K_INVALID = 4'd9;
  localparam kind_t K_END     = 4'd10;

  // character codes
  typedef logic [CHAR_W-1:0] char_t;
  localparam char_t ASC_LC_A   = 8'h61;
  localparam char_t ASC_LC_Z   = 8'h7A;
  localparam char_t ASC_UC_A   = 8'h41;
  localparam char_t ASC_UC_Z   = 8'h5A;
  localparam char_t ASC_ZERO   = 8'h30;
  localparam char_t ASC_NINE   = 8'h39;
  localparam char_t ASC_UNDER  = 8'h5F;
  localparam char_t ASC_COLON  = 8'h3A;
  localparam char_t ASC_EQUAL  = 8'h3D;
  localparam char_t ASC_SEMI   = 8'h3B;
  localparam char_t ASC_LPAREN = 8'h28;
  localparam char_t ASC_RPAREN = 8'h29;
  localparam char_t ASC_QUOTE  = 8'h22;
  localparam char_t ASC_PLUS   = 8'h2B;
  localparam char_t ASC_MINUS  = 8'h2D;
  localparam char_t ASC_STAR   = 8'h2A;
  localparam char_t ASC_SLASH  = 8'h2F;
  localparam char_t ASC_PCT    = 8'h25;

  // source of the character carried by a result
  typedef enum logic [2:0] {
    CH_NONE,
    CH_BUF,
    CH_BYTE,
    CH_COLON,
    CH_EQUAL
  } csel_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    csel_t csel;
    logic  token_done;
    logic  run_done;
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  append;
    logic  start_append;
    logic  clear;
    logic  fl_start;
    logic  fl_read;
    logic  fl_next;
    emit_t emit;
  } dp_cmd_t;

  typedef struct packed {
    logic  is_alpha;
    logic  is_digit;
    logic  is_under;
    logic  is_colon;
    logic  is_equal;
    logic  is_quote;
    logic  is_single;
    kind_t single_kind;
    logic  kw_hit;
    logic  fl_last;
    logic  len_zero;
    logic  emit_ok;
  } dp_stat_t;

  // the one keyword, "afficher", one character per position
  function automatic char_t kw_char(input logic [2:0] pos);
    char_t c;
    case (pos)
      3'd0:    c = 8'h61;
      3'd1:    c = 8'h66;
      3'd2:    c = 8'h66;
      3'd3:    c = 8'h69;
      3'd4:    c = 8'h63;
      3'd5:    c = 8'h68;
      3'd6:    c = 8'h65;
      default: c = 8'h72;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tll_ram.sv =====
// ----------------------------------------------------------------------------
// tll_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tll_datapath.sv =====
// ----------------------------------------------------------------------------
// tll_datapath
// Byte register and classifier, value buffer with length, overflow and
// keyword tracking, readout index and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tll_datapath
  import tll_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire char_t    in_byte,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      st,
  input  wire logic     out_ready,
  output logic          out_valid,
  output kind_t         out_kind,
  output char_t         out_char,
  output logic          out_cvalid,
  output logic [INDEX_W-1:0] out_index,
  output logic          out_trunc,
  output logic          out_token_done,
  output logic          out_run_done
);

  localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_TOKEN_LEN);

  char_t             byte_q;
  logic [LEN_W-1:0]  length;
  logic              overflow;
  logic              kw_match;
  logic [LEN_W-1:0]  idx;
  char_t             rd_data;
  logic              room;
  logic              kw_pos;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  // character classes of the held byte
  always_comb begin
    st = '0;
    st.is_alpha = ((byte_q >= ASC_LC_A) && (byte_q <= ASC_LC_Z)) ||
                  ((byte_q >= ASC_UC_A) && (byte_q <= ASC_UC_Z));
    st.is_digit = (byte_q >= ASC_ZERO) && (byte_q <= ASC_NINE);
    st.is_under = (byte_q == ASC_UNDER);
    st.is_colon = (byte_q == ASC_COLON);
    st.is_equal = (byte_q == ASC_EQUAL);
    st.is_quote = (byte_q == ASC_QUOTE);
    st.single_kind = K_OPER;
    case (byte_q)
      ASC_SEMI:   begin st.is_single = 1'b1; st.single_kind = K_SEMI;   end
      ASC_LPAREN: begin st.is_single = 1'b1; st.single_kind = K_LPAREN; end
      ASC_RPAREN: begin st.is_single = 1'b1; st.single_kind = K_RPAREN; end
      ASC_PLUS, ASC_MINUS, ASC_STAR, ASC_SLASH, ASC_PCT: begin
        st.is_single = 1'b1;
      end
      default: st.is_single = 1'b0;
    endcase
    st.kw_hit   = kw_match && !overflow && (length == LEN_W'(KW_LEN));
    st.len_zero = (length == '0);
    st.fl_last  = st.len_zero || ((idx + 1'b1) == length);
    st.emit_ok  = !out_valid || out_ready;
  end

  assign room    = (length < LEN_W'(MAX_TOKEN_LEN));
  assign kw_pos  = (length < LEN_W'(KW_LEN));
  assign wr_en   = cmd.start_append || (cmd.append && room);
  assign wr_addr = cmd.start_append ? '0 : length[ADDR_W-1:0];

  // value buffer
  tll_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_TOKEN_LEN)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (byte_q),
    .rd_en   (cmd.fl_read),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // held byte, readout index and keyword match
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= in_byte;
    end
    if (cmd.fl_start) begin
      idx <= '0;
    end else if (cmd.fl_next) begin
      idx <= idx + 1'b1;
    end
    if (cmd.start_append) begin
      kw_match <= (byte_q == kw_char(3'd0));
    end else if (cmd.clear) begin
      kw_match <= 1'b1;
    end else if (cmd.append && kw_pos) begin
      kw_match <= kw_match && (byte_q == kw_char(length[2:0]));
    end
  end

  // value length and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      overflow <= 1'b0;
    end else if (cmd.start_append) begin
      length   <= LEN_W'(1);
      overflow <= 1'b0;
    end else if (cmd.clear) begin
      length   <= '0;
      overflow <= 1'b0;
    end else if (cmd.append) begin
      if (room) begin
        length <= length + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit.valid) begin
      out_kind       <= cmd.emit.kind;
      out_cvalid     <= (cmd.emit.csel != CH_NONE);
      out_trunc      <= (cmd.emit.csel == CH_BUF) && overflow;
      out_token_done <= cmd.emit.token_done;
      out_run_done   <= cmd.emit.run_done;
      case (cmd.emit.csel)
        CH_BUF:   out_char <= rd_data;
        CH_BYTE:  out_char <= byte_q;
        CH_COLON: out_char <= ASC_COLON;
        CH_EQUAL: out_char <= ASC_EQUAL;
        default:  out_char <= '0;
      endcase
      case (cmd.emit.csel)
        CH_BUF:   out_index <= INDEX_W'(idx);
        CH_EQUAL: out_index <= INDEX_W'(1);
        default:  out_index <= '0;
      endcase
    end
  end

  // checks
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit.valid |-> (!out_valid || out_ready))
    else $error("result loaded while the previous beat was still held");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (length == LEN_W'(MAX_TOKEN_LEN)))
    else $error("overflow flagged with room left in the buffer");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_cvalid) |-> ((out_index == '0) && !out_trunc && (out_char == '0)))
    else $error("empty-valued result carries character data");

endmodule

`default_nettype wire

// ===== rtl/core/tll_ctrl.sv =====
// ----------------------------------------------------------------------------
// tll_ctrl
// Lexer controller: tracks the lexing mode and sequences each input beat
// through decode, buffer readout and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tll_ctrl
  import tll_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_present,
  input  wire logic     in_ending,
  output logic          in_ready,
  input  wire dp_stat_t st,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_IDLE_BYTE,
    S_SINGLE,
    S_ASSIGN0,
    S_ASSIGN1,
    S_END_CHECK,
    S_INVALID,
    S_END,
    S_FL_RD,
    S_FL_EM
  } state_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_WORD,
    M_NUM,
    M_COLON,
    M_STR
  } mode_t;

  state_t state;
  mode_t  mode;
  logic   present;
  logic   ending;
  kind_t  flush_kind;
  state_t flush_ret;
  logic   flush_run;
  logic   word_cont;

  assign word_cont = st.is_alpha || st.is_digit || st.is_under;
  assign in_ready  = (state == S_IDLE);

  // state, mode and flush bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= M_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            present <= in_present;
            ending  <= in_ending;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (!present) begin
            state <= S_END_CHECK;
          end else begin
            unique case (mode)
              M_WORD: begin
                if (word_cont) begin
                  state <= S_END_CHECK;
                end else begin
                  flush_kind <= st.kw_hit ? K_KEYWORD : K_IDENT;
                  flush_ret  <= S_IDLE_BYTE;
                  flush_run  <= !ending && !st.is_single;
                  state      <= S_FL_RD;
                end
              end
              M_NUM: begin
                if (st.is_digit) begin
                  state <= S_END_CHECK;
                end else begin
                  flush_kind <= K_NUMBER;
                  flush_ret  <= S_IDLE_BYTE;
                  flush_run  <= !ending && !st.is_single;
                  state      <= S_FL_RD;
                end
              end
              M_STR: begin
                if (st.is_quote) begin
                  flush_kind <= K_STRING;
                  flush_ret  <= S_END_CHECK;
                  flush_run  <= !ending;
                  state      <= S_FL_RD;
                end else begin
                  state <= S_END_CHECK;
                end
              end
              M_COLON: begin
                mode <= M_IDLE;
                if (st.is_equal) begin
                  state <= S_ASSIGN0;
                end else if (st.is_single || st.is_quote) begin
                  state <= S_IDLE_BYTE;
                end else begin
                  state <= S_END_CHECK;
                end
              end
              default: state <= S_IDLE_BYTE;
            endcase
          end
        end
        S_IDLE_BYTE: begin
          if (st.is_alpha) begin
            mode  <= M_WORD;
            state <= S_END_CHECK;
          end else if (st.is_digit) begin
            mode  <= M_NUM;
            state <= S_END_CHECK;
          end else if (st.is_colon) begin
            mode  <= M_COLON;
            state <= S_END_CHECK;
          end else if (st.is_quote) begin
            mode  <= M_STR;
            state <= S_END_CHECK;
          end else if (st.is_single) begin
            state <= S_SINGLE;
          end else begin
            state <= S_END_CHECK;
          end
        end
        S_SINGLE: begin
          if (st.emit_ok) begin
            state <= S_END_CHECK;
          end
        end
        S_ASSIGN0: begin
          if (st.emit_ok) begin
            state <= S_ASSIGN1;
          end
        end
        S_ASSIGN1: begin
          if (st.emit_ok) begin
            state <= S_END_CHECK;
          end
        end
        S_END_CHECK: begin
          if (!ending) begin
            state <= S_IDLE;
          end else begin
            unique case (mode)
              M_WORD, M_NUM: begin
                if (mode == M_WORD) begin
                  flush_kind <= st.kw_hit ? K_KEYWORD : K_IDENT;
                end else begin
                  flush_kind <= K_NUMBER;
                end
                flush_ret <= S_END;
                flush_run <= 1'b0;
                state     <= S_FL_RD;
              end
              M_STR:   state <= S_INVALID;
              default: state <= S_END;
            endcase
          end
        end
        S_INVALID: begin
          if (st.emit_ok) begin
            state <= S_END;
          end
        end
        S_END: begin
          if (st.emit_ok) begin
            mode  <= M_IDLE;
            state <= S_IDLE;
          end
        end
        S_FL_RD: state <= S_FL_EM;
        S_FL_EM: begin
          if (st.emit_ok) begin
            if (st.fl_last) begin
              mode  <= M_IDLE;
              state <= flush_ret;
            end else begin
              state <= S_FL_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.load = in_valid;
      S_DECODE: begin
        if (present) begin
          unique case (mode)
            M_WORD: begin
              cmd.append   = word_cont;
              cmd.fl_start = !word_cont;
            end
            M_NUM: begin
              cmd.append   = st.is_digit;
              cmd.fl_start = !st.is_digit;
            end
            M_STR: begin
              cmd.append   = !st.is_quote;
              cmd.fl_start = st.is_quote;
            end
            default: cmd.append = 1'b0;
          endcase
        end
      end
      S_IDLE_BYTE: begin
        cmd.start_append = st.is_alpha || st.is_digit;
        cmd.clear        = st.is_quote;
      end
      S_SINGLE: begin
        if (st.emit_ok) begin
          cmd.emit = '{valid: 1'b1, kind: st.single_kind, csel: CH_BYTE,
                       token_done: 1'b1, run_done: !ending};
        end
      end
      S_ASSIGN0: begin
        if (st.emit_ok) begin
          cmd.emit = '{valid: 1'b1, kind: K_ASSIGN, csel: CH_COLON,
                       token_done: 1'b0, run_done: 1'b0};
        end
      end
      S_ASSIGN1: begin
        if (st.emit_ok) begin
          cmd.emit = '{valid: 1'b1, kind: K_ASSIGN, csel: CH_EQUAL,
                       token_done: 1'b1, run_done: !ending};
        end
      end
      S_END_CHECK: cmd.fl_start = ending && ((mode == M_WORD) || (mode == M_NUM));
      S_INVALID: begin
        if (st.emit_ok) begin
          cmd.emit = '{valid: 1'b1, kind: K_INVALID, csel: CH_NONE,
                       token_done: 1'b1, run_done: 1'b0};
        end
      end
      S_END: begin
        if (st.emit_ok) begin
          cmd.emit  = '{valid: 1'b1, kind: K_END, csel: CH_NONE,
                        token_done: 1'b1, run_done: 1'b1};
          cmd.clear = 1'b1;
        end
      end
      S_FL_RD: cmd.fl_read = 1'b1;
      S_FL_EM: begin
        if (st.emit_ok) begin
          cmd.emit = '{valid: 1'b1, kind: flush_kind,
                       csel: st.len_zero ? CH_NONE : CH_BUF,
                       token_done: st.fl_last, run_done: st.fl_last && flush_run};
          cmd.clear   = st.fl_last;
          cmd.fl_next = !st.fl_last;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/toy_language_lexer_top.sv =====
// ----------------------------------------------------------------------------
// toy_language_lexer_top
// Lexer for a small toy language: source bytes in, token characters out.
//
//   channel  dir  beat carries
//   s_*      in   one source byte, byte-present flag, end of text
//   m_*      out  one character of a token value with kind and flags
//
// An input beat that yields no result passes decode and the end check in the
// controller, some beats also the idle-byte step. Each buffered value
// character (words, numbers, strings) takes a buffer read then the result load;
// single-character and assignment results skip the read. The value buffer has
// a single read port. A stalled output beat holds the controller at the next
// result load. Synchronous reset returns the lexer to idle with an empty value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module toy_language_lexer_top
  import tll_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic [0:0]  s_tuser,   // [0] byte_present
  input  wire logic        s_tlast,   // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] value_char, [13:8] char_index, [15:14] zero
  output logic [6:0]       m_tuser,   // [3:0] token_kind, [4] char_valid,
                                      // [5] value_truncated, [6] run_done
  output logic             m_tlast    // token_done
);

  dp_cmd_t             cmd;
  dp_stat_t            st;
  kind_t               out_kind;
  char_t               out_char;
  logic                out_cvalid;
  logic [INDEX_W-1:0]  out_index;
  logic                out_trunc;
  logic                out_token_done;
  logic                out_run_done;

  // controller
  tll_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_present (s_tuser[0]),
    .in_ending  (s_tlast),
    .in_ready   (s_tready),
    .st         (st),
    .cmd        (cmd)
  );

  // datapath
  tll_datapath #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_byte        (s_tdata),
    .cmd            (cmd),
    .st             (st),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_kind       (out_kind),
    .out_char       (out_char),
    .out_cvalid     (out_cvalid),
    .out_index      (out_index),
    .out_trunc      (out_trunc),
    .out_token_done (out_token_done),
    .out_run_done   (out_run_done)
  );

  // output beat packing
  assign m_tdata = {2'b00, out_index, out_char};
  assign m_tuser = {out_run_done, out_trunc, out_cvalid, out_kind};
  assign m_tlast = out_token_done;

endmodule

`default_nettype wire

// ===== test/toy_language_lexer_top_test.sv =====
// ----------------------------------------------------------------------------
// toy_language_lexer_top_test
// Self-checking bench for the toy language lexer. A short table of source
// bytes covers each token kind but the keyword, the lone colon, dropped bytes,
// strings with binary content and the end-of-text cases. Random source text
// of well-formed tokens with random content, plus noise, follows. Each output
// beat is checked against the table or a local lexer model. Both stream sides
// idle at random; one long receiver hold-off backs the lexer up onto its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module toy_language_lexer_top_test;
  import tll_pkg::*;

  localparam int MAX_LEN      = 32;
  localparam int N_ITEMS      = 330;
  localparam int N_DIRECTED   = 25;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AFTER   = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  localparam char_t ASC_SPACE = 8'h20;
  localparam char_t ASC_TAB   = 8'h09;
  localparam char_t ASC_FF    = 8'hFF;
  localparam char_t ASC_NUL   = 8'h00;
  localparam char_t ASC_LC_Q  = 8'h71;
  localparam char_t ASC_LC_X  = 8'h78;
  localparam char_t ASC_ONE   = 8'h31;
  localparam char_t ASC_SEVEN = 8'h37;
  localparam logic [63:0] KW_TEXT = "afficher";

  // kind column is only read on rows marked typed
  localparam kind_t NO_KIND = K_INVALID;

  typedef enum logic [2:0] {
    LX_IDLE,
    LX_WORD,
    LX_NUM,
    LX_COLON,
    LX_STR
  } lex_mode_t;

  // one output beat as the lexer should present it
  typedef struct packed {
    kind_t      kind;
    char_t      ch;
    logic       cvalid;
    logic [5:0] idx;
    logic       trunc;
    logic       tdone;
    logic       rdone;
  } tok_char_t;

  // one input beat
  typedef struct packed {
    char_t b;
    logic  present;
    logic  eot;
    logic  typed;
    kind_t k;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] text_byte
  logic [0:0]  s_tuser = '0;   // [0] byte_present
  logic        s_tlast = 1'b0; // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [7:0] value_char, [13:8] char_index, [15:14] zero
  logic [6:0]  m_tuser;        // [3:0] token_kind, [4] char_valid,
                               // [5] value_truncated, [6] run_done
  logic        m_tlast;        // token_done

  // lexer model state
  lex_mode_t   lx_mode = LX_IDLE;
  char_t       val_buf [MAX_LEN];
  int unsigned val_len = 0;
  logic        val_ovf = 1'b0;
  tok_char_t   item_out [$];

  tok_char_t   expected_chars [$];
  src_item_t   source_text [$];

  int          bytes_taken = 0;
  int          chars_checked = 0;
  int          tokens_seen = 0;
  int          truncated_tokens = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  logic [10:0] kinds_seen = '0;
  logic        hold_off = 1'b0;

  src_item_t directed_rows [N_DIRECTED] = '{
    '{ASC_NUL,    1'b0, 1'b1, 1'b1, K_END},     // end with no byte, straight after reset
    '{ASC_UC_A,   1'b0, 1'b0, 1'b0, NO_KIND},   // empty beat, nothing comes out
    '{ASC_SEMI,   1'b1, 1'b0, 1'b1, K_SEMI},
    '{ASC_LPAREN, 1'b1, 1'b0, 1'b1, K_LPAREN},
    '{ASC_RPAREN, 1'b1, 1'b0, 1'b1, K_RPAREN},
    '{ASC_PLUS,   1'b1, 1'b0, 1'b1, K_OPER},
    '{ASC_STAR,   1'b1, 1'b0, 1'b1, K_OPER},
    '{ASC_SLASH,  1'b1, 1'b0, 1'b1, K_OPER},
    '{ASC_PCT,    1'b1, 1'b0, 1'b1, K_OPER},
    '{ASC_FF,     1'b1, 1'b0, 1'b0, NO_KIND},   // high byte outside a string is dropped
    '{ASC_LC_X,   1'b1, 1'b0, 1'b0, NO_KIND},
    '{ASC_ONE,    1'b1, 1'b0, 1'b0, NO_KIND},
    '{ASC_LPAREN, 1'b1, 1'b0, 1'b0, NO_KIND},   // flushes the word, then its own token
    '{ASC_COLON,  1'b1, 1'b0, 1'b0, NO_KIND},
    '{ASC_EQUAL,  1'b1, 1'b0, 1'b0, NO_KIND},   // assignment pair
    '{ASC_COLON,  1'b1, 1'b0, 1'b0, NO_KIND},
    '{ASC_LC_A,   1'b1, 1'b0, 1'b0, NO_KIND},   // lone colon swallows a letter
    '{ASC_COLON,  1'b1, 1'b0, 1'b0, NO_KIND},
    '{ASC_MINUS,  1'b1, 1'b0, 1'b1, K_OPER},    // lone colon lets an operator through
    '{ASC_QUOTE,  1'b1, 1'b0, 1'b0, NO_KIND},
    '{ASC_NUL,    1'b1, 1'b0, 1'b0, NO_KIND},   // control byte kept inside a string
    '{ASC_QUOTE,  1'b1, 1'b0, 1'b0, NO_KIND},
    '{ASC_QUOTE,  1'b1, 1'b0, 1'b0, NO_KIND},
    '{ASC_LC_Q,   1'b1, 1'b1, 1'b0, NO_KIND},   // open string at end of text
    '{ASC_SEVEN,  1'b1, 1'b1, 1'b0, NO_KIND}    // number flushed at end of text
  };

  toy_language_lexer_top #(
    .MAX_TOKEN_LEN(MAX_LEN)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  always #5 clk = ~clk;

  // character classes
  function automatic logic is_letter(input char_t c);
    return (c >= ASC_LC_A && c <= ASC_LC_Z) || (c >= ASC_UC_A && c <= ASC_UC_Z);
  endfunction

  function automatic logic is_digit(input char_t c);
    return c >= ASC_ZERO && c <= ASC_NINE;
  endfunction

  function automatic logic is_op(input char_t c);
    return c == ASC_PLUS || c == ASC_MINUS || c == ASC_STAR || c == ASC_SLASH ||
           c == ASC_PCT;
  endfunction

  function automatic logic is_punct(input char_t c);
    return c == ASC_SEMI || c == ASC_LPAREN || c == ASC_RPAREN || c == ASC_QUOTE ||
           is_op(c);
  endfunction

  // queue the beats of one token; an empty value still gives one beat
  function automatic void emit_token(input kind_t k, input int unsigned len,
                                     input logic from_buf, input char_t c0,
                                     input logic trunc);
    int unsigned n;
    int unsigned i;
    tok_char_t   r;
    n = (len == 0) ? 1 : len;
    for (i = 0; i < n; i++) begin
      r.kind = k;
      if (len == 0) r.ch = '0;
      else if (from_buf) r.ch = val_buf[i];
      else r.ch = (i == 0) ? c0 : ASC_EQUAL;
      r.cvalid = (len != 0);
      r.idx    = (len != 0) ? i[5:0] : '0;
      r.trunc  = trunc;
      r.tdone  = (i + 1 == n);
      r.rdone  = 1'b0;
      item_out = {item_out, r};
    end
  endfunction

  function automatic void take_char(input char_t c);
    if (val_len < MAX_LEN) begin
      val_buf[val_len] = c;
      val_len++;
    end else begin
      val_ovf = 1'b1;
    end
  endfunction

  function automatic void clear_value();
    val_len = 0;
    val_ovf = 1'b0;
  endfunction

  // pending word or number leaves as a token
  function automatic void flush_pending();
    kind_t       k;
    logic        kw;
    int unsigned i;
    k = K_NUMBER;
    if (lx_mode == LX_WORD) begin
      k  = K_IDENT;
      kw = !val_ovf && val_len == 8;
      for (i = 0; i < 8; i++)
        if (kw && val_buf[i] != KW_TEXT[8*(7-i) +: 8]) kw = 1'b0;
      if (kw) k = K_KEYWORD;
    end
    emit_token(k, val_len, 1'b1, '0, val_ovf);
    lx_mode = LX_IDLE;
    clear_value();
  endfunction

  // byte seen with nothing pending
  function automatic void lex_fresh(input char_t c);
    if (is_letter(c)) begin
      clear_value();
      take_char(c);
      lx_mode = LX_WORD;
    end else if (is_digit(c)) begin
      clear_value();
      take_char(c);
      lx_mode = LX_NUM;
    end else if (c == ASC_COLON) begin
      lx_mode = LX_COLON;
    end else if (c == ASC_SEMI) begin
      emit_token(K_SEMI, 1, 1'b0, c, 1'b0);
    end else if (c == ASC_LPAREN) begin
      emit_token(K_LPAREN, 1, 1'b0, c, 1'b0);
    end else if (c == ASC_RPAREN) begin
      emit_token(K_RPAREN, 1, 1'b0, c, 1'b0);
    end else if (c == ASC_QUOTE) begin
      clear_value();
      lx_mode = LX_STR;
    end else if (is_op(c)) begin
      emit_token(K_OPER, 1, 1'b0, c, 1'b0);
    end
  endfunction

  function automatic void lex_byte(input char_t c);
    case (lx_mode)
      LX_WORD: begin
        if (is_letter(c) || is_digit(c) || c == ASC_UNDER) begin
          take_char(c);
        end else begin
          flush_pending();
          lex_fresh(c);
        end
      end
      LX_NUM: begin
        if (is_digit(c)) begin
          take_char(c);
        end else begin
          flush_pending();
          lex_fresh(c);
        end
      end
      LX_STR: begin
        if (c == ASC_QUOTE) begin
          emit_token(K_STRING, val_len, 1'b1, '0, val_ovf);
          lx_mode = LX_IDLE;
          clear_value();
        end else begin
          take_char(c);
        end
      end
      LX_COLON: begin
        lx_mode = LX_IDLE;
        if (c == ASC_EQUAL) emit_token(K_ASSIGN, 2, 1'b0, ASC_COLON, 1'b0);
        else if (is_punct(c)) lex_fresh(c);
      end
      default: begin
        lx_mode = LX_IDLE;
        lex_fresh(c);
      end
    endcase
  endfunction

  // all beats that one accepted input beat should cause
  function automatic void lex_item(input char_t b, input logic present, input logic eot);
    tok_char_t r;
    item_out.delete();
    if (present) lex_byte(b);
    if (eot) begin
      if (lx_mode == LX_WORD || lx_mode == LX_NUM) flush_pending();
      else if (lx_mode == LX_STR) emit_token(K_INVALID, 0, 1'b1, '0, 1'b0);
      lx_mode = LX_IDLE;
      clear_value();
      emit_token(K_END, 0, 1'b1, '0, 1'b0);
    end
    if (item_out.size() > 0) begin
      r = item_out.pop_back();
      r.rdone = 1'b1;
      item_out = {item_out, r};
    end
  endfunction

  // source text building
  function automatic void add_item(input char_t b, input logic present, input logic eot);
    src_item_t it;
    it         = '0;
    it.b       = b;
    it.present = present;
    it.eot     = eot;
    source_text = {source_text, it};
  endfunction

  function automatic char_t rand_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return (r < 26) ? char_t'(ASC_LC_A + r) : char_t'(ASC_UC_A + r - 26);
  endfunction

  function automatic char_t rand_digit();
    return char_t'(ASC_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic char_t rand_word_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return rand_letter();
    if (r < 9) return rand_digit();
    return ASC_UNDER;
  endfunction

  function automatic char_t rand_punct();
    char_t p [9];
    p = '{ASC_SEMI, ASC_LPAREN, ASC_RPAREN, ASC_PLUS, ASC_MINUS, ASC_STAR,
          ASC_SLASH, ASC_PCT, ASC_QUOTE};
    return p[$urandom_range(0, 8)];
  endfunction

  // tab, line feed, vertical tab, form feed, carriage return or space
  function automatic char_t rand_space();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? ASC_SPACE : char_t'(ASC_TAB + r);
  endfunction

  // value lengths: mostly short, now and then past the buffer
  function automatic int unsigned rand_len(input int unsigned lo);
    return ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_LEN - 2, MAX_LEN + 8)
                                        : $urandom_range(lo, 8);
  endfunction

  function automatic void add_random_text();
    int unsigned pick;
    int unsigned len;
    int unsigned v;
    int unsigned pos;
    int unsigned i;
    char_t       c;
    while (source_text.size() < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        // identifier
        len = rand_len(1);
        add_item(rand_letter(), 1'b1, 1'b0);
        for (i = 1; i < len; i++) add_item(rand_word_char(), 1'b1, 1'b0);
      end else if (pick < 30) begin
        // keyword and near misses
        v   = $urandom_range(0, 9);
        pos = $urandom_range(0, 7);
        for (i = 0; i < 8; i++) begin
          c = KW_TEXT[8*(7-i) +: 8];
          if (v == 7 && i == pos) c = rand_letter();
          if (v == 9 && i == 0) c = ASC_UC_A;
          if (!(v == 8 && i == 7)) add_item(c, 1'b1, 1'b0);
        end
        if (v == 6) add_item(rand_word_char(), 1'b1, 1'b0);
      end else if (pick < 44) begin
        // number
        len = rand_len(1);
        for (i = 0; i < len; i++) add_item(rand_digit(), 1'b1, 1'b0);
      end else if (pick < 52) begin
        add_item(ASC_COLON, 1'b1, 1'b0);
        add_item(ASC_EQUAL, 1'b1, 1'b0);
      end else if (pick < 58) begin
        // lone colon and whatever follows it
        add_item(ASC_COLON, 1'b1, 1'b0);
        v = $urandom_range(0, 2);
        if (v == 0) add_item(rand_punct(), 1'b1, 1'b0);
        else if (v == 1) add_item(char_t'($urandom_range(0, 255)), 1'b1, 1'b0);
        else add_item(rand_letter(), 1'b1, 1'b0);
      end else if (pick < 72) begin
        c = rand_punct();
        if (c == ASC_QUOTE) c = ASC_SEMI;
        add_item(c, 1'b1, 1'b0);
      end else if (pick < 84) begin
        // string with any content, sometimes cut off by end of text
        len = rand_len(0);
        add_item(ASC_QUOTE, 1'b1, 1'b0);
        for (i = 0; i < len; i++) begin
          do c = char_t'($urandom_range(0, 255)); while (c == ASC_QUOTE);
          add_item(c, 1'b1, 1'b0);
        end
        if ($urandom_range(0, 9) == 0) add_item(char_t'($urandom_range(0, 255)), 1'b0, 1'b1);
        else add_item(ASC_QUOTE, 1'b1, 1'b0);
      end else if (pick < 90) begin
        add_item(char_t'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else if (pick < 94) begin
        add_item(char_t'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else begin
        add_item(char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end
      // separator, often none so tokens run into each other
      if ($urandom_range(0, 99) >= 55) add_item(rand_space(), 1'b1, 1'b0);
    end
    add_item(ASC_NUL, 1'b0, 1'b1);
  endfunction

  // idle lengths: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic string show_char(input tok_char_t t);
    return $sformatf("kind %0d char %h valid %b index %0d trunc %b done %b run %b",
                     t.kind, t.ch, t.cvalid, t.idx, t.trunc, t.tdone, t.rdone);
  endfunction

  // receiver pacing
  initial begin : sink_pacing
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned r;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (calm_left > 0) calm_left--;
      else if (stall_left > 0) stall_left--;
      else if (r < 2) calm_left = $urandom_range(30, 80);
      else if (r < 25) stall_left = pick_gap() + 1;
      m_tready <= !hold_off && (stall_left == 0);
    end
  end

  // one long receiver hold-off while the sender keeps offering beats
  initial begin : long_hold
    wait (bytes_taken >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // output beat check
  always @(posedge clk) begin : token_check
    tok_char_t got;
    tok_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind   = m_tuser[3:0];
      got.ch     = m_tdata[7:0];
      got.cvalid = m_tuser[4];
      got.idx    = m_tdata[13:8];
      got.trunc  = m_tuser[5];
      got.tdone  = m_tlast;
      got.rdone  = m_tuser[6];
      chars_checked++;
      if (got.tdone) begin
        tokens_seen++;
        if (got.kind <= K_END) kinds_seen[got.kind] = 1'b1;
        if (got.trunc) truncated_tokens++;
      end
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: %s", show_char(got));
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch on beat %0d", chars_checked);
            $display("  expected %s", show_char(want));
            $display("  actual   %s", show_char(got));
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_chars.size());
      $display("status: fail");
      $finish;
    end
  end

  // stimulus and prediction
  initial begin : source_feed
    src_item_t   it;
    tok_char_t   want;
    int unsigned gap;
    int unsigned calm_left;
    int          j;
    calm_left = 0;
    foreach (directed_rows[n]) source_text = {source_text, directed_rows[n]};
    add_random_text();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (source_text[n]) begin
      it = source_text[n];
      if (calm_left > 0) begin
        gap = 0;
        calm_left--;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 40);
      end
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= it.b;
      s_tuser  <= it.present;
      s_tlast  <= it.eot;
      do @(posedge clk); while (!s_tready);
      bytes_taken++;

      lex_item(it.b, it.present, it.eot);
      if (it.typed) begin
        // single-beat tokens whose value is the byte itself, or empty
        want.kind   = it.k;
        want.ch     = it.present ? it.b : '0;
        want.cvalid = it.present;
        want.idx    = '0;
        want.trunc  = 1'b0;
        want.tdone  = 1'b1;
        want.rdone  = 1'b1;
        expected_chars = {expected_chars, want};
      end else begin
        for (j = 0; j < item_out.size(); j++) expected_chars = {expected_chars, item_out[j]};
      end
    end
    s_tvalid <= 1'b0;

    // drain, then a little extra for stray beats
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d source beats, %0d token beats in %0d tokens, %0d truncated",
             bytes_taken, chars_checked, tokens_seen, truncated_tokens);
    $display("token kinds seen (end down to keyword) %b, receiver held off %0d cycles once",
             kinds_seen, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== toy_language_lexer_top.f =====
rtl/core/tll_pkg.sv
rtl/core/tll_ram.sv
rtl/core/tll_datapath.sv
rtl/core/tll_ctrl.sv
rtl/core/toy_language_lexer_top.sv
test/toy_language_lexer_top_test.sv
